FILE: rtl/core/mlpbp_pkg.sv
// ----------------------------------------------------------------------------
// mlpbp_pkg: shared constants, types and arithmetic helpers
// Fixed-point helpers, sigmoid table and codes for the MLP trainer core.
// ----------------------------------------------------------------------------
package mlpbp_pkg;

    // network shape (hidden width is a top-level parameter)
    localparam int N_INPUTS     = 4;
    localparam int N_OUTPUTS    = 2;
    localparam int N_HIDDEN_DEF = 3;
    localparam int N_WEIGHTS_DEF = N_HIDDEN_DEF * (N_INPUTS + N_OUTPUTS + 1) + N_OUTPUTS;
    localparam int ADDR_W_DEF    = $clog2(N_WEIGHTS_DEF);

    // datapath widths
    localparam int ACC_W   = 52;
    localparam int PROD_W  = 50;
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 18;
    localparam int ONE_Q12 = 4096;

    // saturation bounds
    localparam int SAT16_HI = 32767;
    localparam int SAT16_LO = -32768;
    localparam int SAT24_HI = 8388607;
    localparam int SAT24_LO = -8388608;

    // register reset values
    localparam logic [15:0] LEARN_RATE_RST = 16'd26214;
    localparam logic [15:0] MOMENTUM_RST   = 16'd39322;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOMENTUM   = 1'b1;

    // item function codes
    localparam logic [1:0] FN_INFER = 2'd0;
    localparam logic [1:0] FN_TRAIN = 2'd1;
    localparam logic [1:0] FN_WRITE = 2'd2;

    // sigmoid table
    localparam int SIG_POINTS = 257;
    localparam logic [63:0] EXP_STEP_Q32 = 64'd4034748382;

    typedef logic [12:0] t_sig_tab [0:SIG_POINTS-1];

    // write request into the weight store
    typedef struct packed {
        logic               en;
        logic signed [23:0] w;
        logic signed [23:0] d;
    } t_wr;

    // Table build, evaluated at elaboration only. Long division by shift/subtract.
    function automatic t_sig_tab build_sig_tab();
        t_sig_tab    tab;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] num;
        logic [63:0] rem;
        logic [63:0] quo;
        tab = '{default: '0};
        e   = 64'd1 << 32;
        for (int m = 0; m <= 128; m++) begin
            den = (64'd1 << 32) + e;
            num = (64'd1 << 44) + (den >> 1);
            rem = '0;
            quo = '0;
            for (int b = 63; b >= 0; b--) begin
                rem = {rem[62:0], num[b]};
                if (rem >= den) begin
                    rem    = rem - den;
                    quo[b] = 1'b1;
                end
            end
            tab[128 + m] = quo[12:0];
            if (m >= 1) begin
                tab[128 - m] = 13'(ONE_Q12) - quo[12:0];
            end
            e = (e * EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
        end
        return tab;
    endfunction

    localparam t_sig_tab SIG_TAB = build_sig_tab();

    // Interpolated sigmoid over [-8, 8), Q4.12 in, unsigned Q1.12 out
    function automatic logic [12:0] sigmoid(logic signed [15:0] x);
        logic [7:0]  k;
        logic [7:0]  f;
        logic [12:0] lo;
        logic [12:0] hi;
        logic [8:0]  d;
        logic [16:0] p;
        k  = {~x[15], x[14:8]};
        f  = x[7:0];
        lo = SIG_TAB[k];
        hi = SIG_TAB[9'(k) + 9'd1];
        d  = 9'(hi - lo);
        p  = 17'(d) * 17'(f) + 17'd128;
        return lo + 13'(p[16:8]);
    endfunction

    // round half up, then arithmetic shift
    function automatic logic signed [ACC_W-1:0] rnd(logic signed [ACC_W-1:0] v, int n);
        logic signed [ACC_W-1:0] half;
        half      = '0;
        half[n-1] = 1'b1;
        return (v + half) >>> n;
    endfunction

    function automatic logic signed [15:0] sat16(logic signed [ACC_W-1:0] v);
        logic signed [15:0] r;
        if (v > SAT16_HI) begin
            r = 16'sh7fff;
        end else if (v < SAT16_LO) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic signed [23:0] sat24(logic signed [ACC_W-1:0] v);
        logic signed [23:0] r;
        if (v > SAT24_HI) begin
            r = 24'sh7fffff;
        end else if (v < SAT24_LO) begin
            r = 24'sh800000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/mlpbp_ifs.sv
// ----------------------------------------------------------------------------
// mlpbp_ifs: channel interfaces of the MLP trainer core
// Item, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------

// input item channel
interface mlpbp_item_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic signed [15:0] in0;
    logic signed [15:0] in1;
    logic signed [15:0] in2;
    logic signed [15:0] in3;
    logic [12:0]        target0;
    logic [12:0]        target1;
    logic [4:0]         weight_index;
    logic signed [23:0] weight_value;

    modport source (output valid, func, in0, in1, in2, in3, target0, target1,
                    weight_index, weight_value, input ready);
    modport sink   (input valid, func, in0, in1, in2, in3, target0, target1,
                    weight_index, weight_value, output ready);
endinterface

// result channel
interface mlpbp_res_if;
    logic        valid;
    logic        ready;
    logic [12:0] out0;
    logic [12:0] out1;

    modport source (output valid, out0, out1, input ready);
    modport sink   (input valid, out0, out1, output ready);
endinterface

// configuration write channel
interface mlpbp_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/mlpbp_store.sv
// ----------------------------------------------------------------------------
// mlpbp_store: weight and momentum store
// Two synchronous arrays sharing one address per port, with a registered read
// and per-entry valid bits so unwritten entries read as zero.
// ----------------------------------------------------------------------------
module mlpbp_store #(
    parameter int DEPTH = mlpbp_pkg::N_WEIGHTS_DEF,
    parameter int AW    = mlpbp_pkg::ADDR_W_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mlpbp_pkg::t_wr     i_wr,
    input  logic [AW-1:0]      i_wr_addr,
    input  logic               i_rd_en,
    input  logic [AW-1:0]      i_rd_addr,
    output logic signed [23:0] o_rd_w,
    output logic signed [23:0] o_rd_d
);
    import mlpbp_pkg::*;

    logic signed [23:0] r_mem_w [0:DEPTH-1];
    logic signed [23:0] r_mem_d [0:DEPTH-1];
    logic [DEPTH-1:0]   r_vld;
    logic signed [23:0] r_wq;
    logic signed [23:0] r_dq;
    logic               r_vq;

    // array writes
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem_w[i_wr_addr] <= i_wr.w;
            r_mem_d[i_wr_addr] <= i_wr.d;
        end
    end

    // valid bits: reset means all entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    // registered read, held between reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_wq <= r_mem_w[i_rd_addr];
            r_dq <= r_mem_d[i_rd_addr];
            r_vq <= r_vld[i_rd_addr];
        end
    end

    assign o_rd_w = r_vq ? r_wq : '0;
    assign o_rd_d = r_vq ? r_dq : '0;

endmodule

FILE: rtl/core/mlp_backprop_momentum_trainer_core.sv
// ----------------------------------------------------------------------------
// mlp_backprop_momentum_trainer_core: 4-H-2 sigmoid MLP with momentum training
//
//   Channel  Dir  Handshake           Payload
//   i_in     in   valid/ready         func, in0..in3, target0/1, weight_index/value
//   o_out    out  valid/ready         out0, out1
//   i_cfg    in   valid/ready (ready=1) index, data
//
// Each multiply-accumulate runs through one shared multiplier and a registered
// store read (states FRD, FMUL, FACC); each weight update steps through the
// states URD, UM1, UM2, UM3 and UWB.
// Reset is synchronous; the store's valid bits clear with it.
// The result register frees the input: a train keeps updating while its
// result waits, and a stalled result only holds the next item at its put.
// ----------------------------------------------------------------------------
module mlp_backprop_momentum_trainer_core #(
    parameter int N_HIDDEN = mlpbp_pkg::N_HIDDEN_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    mlpbp_item_if.sink      i_in,
    mlpbp_res_if.source     o_out,
    mlpbp_cfg_if.sink       i_cfg
);
    import mlpbp_pkg::*;

    localparam int NW      = N_HIDDEN * (N_INPUTS + N_OUTPUTS + 1) + N_OUTPUTS;
    localparam int AW      = $clog2(NW);
    localparam int HW      = (N_HIDDEN > 1) ? $clog2(N_HIDDEN) : 1;
    localparam int IW      = $clog2(N_INPUTS);
    localparam int OW      = $clog2(N_OUTPUTS);
    localparam int BASE_HO = N_HIDDEN * N_INPUTS;
    localparam int BASE_BH = N_HIDDEN * (N_INPUTS + N_OUTPUTS);
    localparam int BASE_BO = N_HIDDEN * (N_INPUTS + N_OUTPUTS + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_FBIAS, S_FBIAS2, S_FRD, S_FMUL, S_FACC, S_FSIG, S_FSIG2,
        S_PUT, S_DM1, S_DM2, S_DM3, S_URD, S_UM1, S_UM2, S_UM3, S_UWB,
        S_HS, S_HSACC, S_HD1, S_HD2, S_HD3
    } t_state;

    typedef enum logic [1:0] {PH_HO, PH_BO, PH_IH, PH_BH} t_phase;

    t_state              r_state;
    t_phase              r_phase;
    logic                r_lay;
    logic                r_train;
    logic [HW-1:0]       r_h;
    logic [IW-1:0]       r_i;
    logic [OW-1:0]       r_o;
    logic signed [15:0]  r_x    [N_INPUTS];
    logic [12:0]         r_tgt  [N_OUTPUTS];
    logic [12:0]         r_hid  [N_HIDDEN];
    logic [12:0]         r_y    [N_OUTPUTS];
    logic signed [15:0]  r_dout [N_OUTPUTS];
    logic signed [15:0]  r_dhid [N_HIDDEN];
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  r_hsum;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [15:0]  r_sarg;
    logic signed [15:0]  r_sq;
    logic signed [23:0]  r_nd;
    logic signed [23:0]  r_wnew;
    logic [15:0]         r_eta;
    logic [15:0]         r_alpha;
    logic                r_ov;
    logic [12:0]         r_out0;
    logic [12:0]         r_out1;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [13:0]        tdiff;
    logic signed [15:0]        upd_delta;
    logic signed [MUL_B_W-1:0] upd_act;
    logic [AW-1:0]             upd_addr;
    logic [AW-1:0]             fwd_bias_addr;
    logic [AW-1:0]             fwd_w_addr;
    logic [AW-1:0]             rd_addr;
    logic                      rd_en;
    logic [AW-1:0]             wr_addr;
    t_wr                       wr;
    logic signed [23:0]        rd_w;
    logic signed [23:0]        rd_d;
    logic signed [23:0]        wnew;
    logic [12:0]               sig_y;
    logic                      in_xfer;
    logic                      wr_ok;
    logic                      put_fire;

    assign in_xfer  = i_in.valid && i_in.ready;
    assign wr_ok    = int'(i_in.weight_index) < NW;
    assign sig_y    = sigmoid(r_sarg);
    assign tdiff    = signed'({1'b0, r_tgt[r_o]}) - signed'({1'b0, r_y[r_o]});
    assign wnew     = sat24(ACC_W'(rd_w) + ACC_W'(r_nd));
    assign put_fire = (r_state == S_PUT) && (!r_ov || o_out.ready);

    // store addresses for the forward pass and the update sweep
    always_comb begin
        fwd_bias_addr = r_lay ? AW'(BASE_BO + int'(r_o)) : AW'(BASE_BH + int'(r_h));
        fwd_w_addr    = r_lay ? AW'(BASE_HO + int'(r_o) * N_HIDDEN + int'(r_h))
                              : AW'(int'(r_h) * N_INPUTS + int'(r_i));
        case (r_phase)
            PH_HO: begin
                upd_addr  = AW'(BASE_HO + int'(r_o) * N_HIDDEN + int'(r_h));
                upd_delta = r_dout[r_o];
                upd_act   = signed'({5'b0, r_hid[r_h]});
            end
            PH_BO: begin
                upd_addr  = AW'(BASE_BO + int'(r_o));
                upd_delta = r_dout[r_o];
                upd_act   = MUL_B_W'(ONE_Q12);
            end
            PH_IH: begin
                upd_addr  = AW'(int'(r_h) * N_INPUTS + int'(r_i));
                upd_delta = r_dhid[r_h];
                upd_act   = MUL_B_W'(r_x[r_i]);
            end
            default: begin
                upd_addr  = AW'(BASE_BH + int'(r_h));
                upd_delta = r_dhid[r_h];
                upd_act   = MUL_B_W'(ONE_Q12);
            end
        endcase
    end

    // store port control
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = fwd_w_addr;
        wr      = '{en: 1'b0, w: '0, d: '0};
        wr_addr = upd_addr;
        case (r_state)
            S_FBIAS: begin
                rd_en   = 1'b1;
                rd_addr = fwd_bias_addr;
            end
            S_FRD: begin
                rd_en   = 1'b1;
            end
            S_URD: begin
                rd_en   = 1'b1;
                rd_addr = upd_addr;
            end
            S_UWB: begin
                wr = '{en: 1'b1, w: wnew, d: r_nd};
            end
            S_IDLE: begin
                wr_addr = AW'(i_in.weight_index);
                if (in_xfer && i_in.func == FN_WRITE && wr_ok) begin
                    wr = '{en: 1'b1, w: i_in.weight_value, d: '0};
                end
            end
            default: ;
        endcase
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_FMUL: begin
                mul_a = MUL_A_W'(rd_w);
                mul_b = r_lay ? signed'({5'b0, r_hid[r_h]}) : MUL_B_W'(r_x[r_i]);
            end
            S_DM1: begin
                mul_a = MUL_A_W'(tdiff);
                mul_b = signed'({5'b0, r_y[r_o]});
            end
            S_DM2: begin
                mul_a = signed'(r_prod[MUL_A_W-1:0]);
                mul_b = signed'({5'b0, 13'(ONE_Q12) - r_y[r_o]});
            end
            S_URD: begin
                mul_a = MUL_A_W'(upd_delta);
                mul_b = upd_act;
            end
            S_UM1: begin
                mul_a = signed'(r_prod[MUL_A_W-1:0]);
                mul_b = signed'({2'b0, r_eta});
            end
            S_UM2: begin
                mul_a = MUL_A_W'(rd_d);
                mul_b = signed'({2'b0, r_alpha});
            end
            S_HS: begin
                mul_a = MUL_A_W'(r_wnew);
                mul_b = MUL_B_W'(r_dout[r_o]);
            end
            S_HD1: begin
                mul_a = signed'({19'b0, r_hid[r_h]});
                mul_b = signed'({5'b0, 13'(ONE_Q12) - r_hid[r_h]});
            end
            S_HD2: begin
                mul_a = signed'(r_prod[MUL_A_W-1:0]);
                mul_b = MUL_B_W'(r_sq);
            end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eta   <= LEARN_RATE_RST;
            r_alpha <= MOMENTUM_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_LEARN_RATE: r_eta   <= i_cfg.data;
                CFG_MOMENTUM:   r_alpha <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // sequencer: forward pass, deltas, update sweep, result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_HO;
            r_lay   <= 1'b0;
            r_train <= 1'b0;
            r_h     <= '0;
            r_i     <= '0;
            r_o     <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (put_fire) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_x[0]  <= i_in.in0;
                        r_x[1]  <= i_in.in1;
                        r_x[2]  <= i_in.in2;
                        r_x[3]  <= i_in.in3;
                        r_tgt[0] <= i_in.target0;
                        r_tgt[1] <= i_in.target1;
                        r_train <= (i_in.func == FN_TRAIN);
                        r_lay   <= 1'b0;
                        r_h     <= '0;
                        if (i_in.func == FN_WRITE) begin
                            r_y[0]  <= '0;
                            r_y[1]  <= '0;
                            r_state <= S_PUT;
                        end else begin
                            r_state <= S_FBIAS;
                        end
                    end
                end
                S_FBIAS: r_state <= S_FBIAS2;
                S_FBIAS2: begin
                    r_acc <= ACC_W'(rd_w) <<< 12;
                    if (r_lay) begin
                        r_h <= '0;
                    end else begin
                        r_i <= '0;
                    end
                    r_state <= S_FRD;
                end
                S_FRD: r_state <= S_FMUL;
                S_FMUL: begin
                    r_prod  <= mul_p;
                    r_state <= S_FACC;
                end
                S_FACC: begin
                    r_acc <= r_acc + ACC_W'(r_prod);
                    r_state <= S_FRD;
                    if (!r_lay) begin
                        if (r_i == IW'(N_INPUTS - 1)) begin
                            r_state <= S_FSIG;
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end else begin
                        if (r_h == HW'(N_HIDDEN - 1)) begin
                            r_state <= S_FSIG;
                        end else begin
                            r_h <= r_h + 1'b1;
                        end
                    end
                end
                S_FSIG: begin
                    r_sarg  <= sat16(rnd(r_acc, 16));
                    r_state <= S_FSIG2;
                end
                S_FSIG2: begin
                    r_state <= S_FBIAS;
                    if (!r_lay) begin
                        r_hid[r_h] <= sig_y;
                        if (r_h == HW'(N_HIDDEN - 1)) begin
                            r_lay <= 1'b1;
                            r_o   <= '0;
                        end else begin
                            r_h <= r_h + 1'b1;
                        end
                    end else begin
                        r_y[r_o] <= sig_y;
                        if (r_o == OW'(N_OUTPUTS - 1)) begin
                            r_state <= S_PUT;
                        end else begin
                            r_o <= r_o + 1'b1;
                        end
                    end
                end
                // result transfer into the output register
                S_PUT: begin
                    if (put_fire) begin
                        r_out0 <= r_y[0];
                        r_out1 <= r_y[1];
                        r_o    <= '0;
                        r_state <= r_train ? S_DM1 : S_IDLE;
                    end
                end
                // output deltas
                S_DM1: begin
                    r_prod  <= mul_p;
                    r_state <= S_DM2;
                end
                S_DM2: begin
                    r_prod  <= mul_p;
                    r_state <= S_DM3;
                end
                S_DM3: begin
                    r_dout[r_o] <= sat16(rnd(ACC_W'(r_prod), 24));
                    r_state     <= S_URD;
                    if (r_o == OW'(N_OUTPUTS - 1)) begin
                        r_phase <= PH_HO;
                        r_h     <= '0;
                        r_o     <= '0;
                        r_hsum  <= '0;
                    end else begin
                        r_o     <= r_o + 1'b1;
                        r_state <= S_DM1;
                    end
                end
                // one weight update: read, eta*prod, alpha*dw, round, write back
                S_URD: begin
                    r_prod  <= mul_p;
                    r_state <= S_UM1;
                end
                S_UM1: begin
                    r_prod  <= mul_p;
                    r_state <= S_UM2;
                end
                S_UM2: begin
                    r_acc   <= ACC_W'(r_prod);
                    r_prod  <= mul_p;
                    r_state <= S_UM3;
                end
                S_UM3: begin
                    r_nd    <= sat24(rnd(r_acc + (ACC_W'(r_prod) <<< 8), 24));
                    r_state <= S_UWB;
                end
                S_UWB: begin
                    r_wnew  <= wnew;
                    r_state <= S_URD;
                    case (r_phase)
                        PH_HO: r_state <= S_HS;
                        PH_BO: begin
                            if (r_o == OW'(N_OUTPUTS - 1)) begin
                                r_phase <= PH_IH;
                                r_h     <= '0;
                                r_i     <= '0;
                            end else begin
                                r_o <= r_o + 1'b1;
                            end
                        end
                        PH_IH: begin
                            if (r_i == IW'(N_INPUTS - 1)) begin
                                r_i <= '0;
                                if (r_h == HW'(N_HIDDEN - 1)) begin
                                    r_phase <= PH_BH;
                                    r_h     <= '0;
                                end else begin
                                    r_h <= r_h + 1'b1;
                                end
                            end else begin
                                r_i <= r_i + 1'b1;
                            end
                        end
                        default: begin
                            if (r_h == HW'(N_HIDDEN - 1)) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_h <= r_h + 1'b1;
                            end
                        end
                    endcase
                end
                // back-propagated sum over the freshly updated output weights
                S_HS: begin
                    r_prod  <= mul_p;
                    r_state <= S_HSACC;
                end
                S_HSACC: begin
                    r_hsum <= r_hsum + ACC_W'(r_prod);
                    if (r_o == OW'(N_OUTPUTS - 1)) begin
                        r_state <= S_HD1;
                    end else begin
                        r_o     <= r_o + 1'b1;
                        r_state <= S_URD;
                    end
                end
                // hidden delta
                S_HD1: begin
                    r_sq    <= sat16(rnd(r_hsum, 16));
                    r_prod  <= mul_p;
                    r_state <= S_HD2;
                end
                S_HD2: begin
                    r_prod  <= mul_p;
                    r_state <= S_HD3;
                end
                S_HD3: begin
                    r_dhid[r_h] <= sat16(rnd(ACC_W'(r_prod), 24));
                    r_hsum      <= '0;
                    r_o         <= '0;
                    r_state     <= S_URD;
                    if (r_h == HW'(N_HIDDEN - 1)) begin
                        r_phase <= PH_BO;
                    end else begin
                        r_h <= r_h + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // weight and momentum store
    mlpbp_store #(
        .DEPTH (NW),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr),
        .i_wr_addr (wr_addr),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_w    (rd_w),
        .o_rd_d    (rd_d)
    );

    // channel outputs
    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_ov;
    assign o_out.out0  = r_out0;
    assign o_out.out1  = r_out1;

endmodule

FILE: rtl/core/mlpbp_chk.sv
// ----------------------------------------------------------------------------
// mlpbp_chk: port-level checks for the MLP trainer core
// Watches the item and result channels; attached to the top level by bind.
// ----------------------------------------------------------------------------
module mlpbp_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [12:0] i_out0,
    input logic [12:0] i_out1
);
    import mlpbp_pkg::*;

    // result held until transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out0) && $stable(i_out1))
        else $error("result changed while stalled");

    // sigmoid outputs never exceed one
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out0 <= 13'(ONE_Q12)) && (i_out1 <= 13'(ONE_Q12)))
        else $error("output above 1.0");

    // an accepted item makes the sequencer busy, which drops input ready
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken on consecutive cycles");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind mlp_backprop_momentum_trainer_core mlpbp_chk u_mlpbp_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out0      (o_out.out0),
    .i_out1      (o_out.out1)
);
